/* rtl/cafp_pkg.sv */
// ============================================================================
// cafp_pkg - shared types and constants for the CAN ASCII frame parser
// Character codes, field widths, the character class struct and hex decode.
// ============================================================================
package cafp_pkg;

    localparam int CAFP_MAX_DATA_BYTES = 8;

    localparam int CHAR_W  = 8;
    localparam int ID_W    = 32;
    localparam int LEN_W   = 4;
    localparam int DATA_W  = 64;
    localparam int NIB_W   = 4;
    localparam int BYTE_W  = 8;

    localparam logic [CHAR_W-1:0] CH_COLON = 8'h3A; // ':'
    localparam logic [CHAR_W-1:0] CH_STD   = 8'h53; // 'S'
    localparam logic [CHAR_W-1:0] CH_EXT   = 8'h58; // 'X'
    localparam logic [CHAR_W-1:0] CH_DATA  = 8'h4E; // 'N'
    localparam logic [CHAR_W-1:0] CH_END   = 8'h3B; // ';'
    localparam logic [CHAR_W-1:0] CH_DIG0  = 8'h30; // '0'
    localparam logic [CHAR_W-1:0] CH_DIG9  = 8'h39; // '9'
    localparam logic [CHAR_W-1:0] CH_UA    = 8'h41; // 'A'
    localparam logic [CHAR_W-1:0] CH_UF    = 8'h46; // 'F'
    localparam logic [CHAR_W-1:0] CH_LA    = 8'h61; // 'a'
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h66; // 'f'

    // Classification of one received character
    typedef struct packed {
        logic             is_colon;
        logic             is_std;
        logic             is_ext;
        logic             is_data;
        logic             is_end;
        logic             is_hex;
        logic [NIB_W-1:0] nibble;
    } t_char_class;

    // Hex digit value; only meaningful when the character is a hex digit
    function automatic logic [NIB_W-1:0] hex_nibble(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] d;
        begin
            d = c - CH_DIG0;
            if (c >= CH_UA && c <= CH_UF) begin
                d = c - CH_UA + 8'd10;
            end else if (c >= CH_LA && c <= CH_LF) begin
                d = c - CH_LA + 8'd10;
            end
            return d[NIB_W-1:0];
        end
    endfunction

endpackage

/* rtl/cafp_char_decode.sv */
// ============================================================================
// cafp_char_decode - character classifier
// Flags the framing characters and decodes hex digits of one registered char.
// ============================================================================
module cafp_char_decode (
    input  logic [cafp_pkg::CHAR_W-1:0] i_char,
    output cafp_pkg::t_char_class       o_class
);
    import cafp_pkg::*;

    always_comb begin
        o_class.is_colon = (i_char == CH_COLON);
        o_class.is_std   = (i_char == CH_STD);
        o_class.is_ext   = (i_char == CH_EXT);
        o_class.is_data  = (i_char == CH_DATA);
        o_class.is_end   = (i_char == CH_END);
        o_class.is_hex   = (i_char >= CH_DIG0 && i_char <= CH_DIG9) ||
                           (i_char >= CH_UA   && i_char <= CH_UF)   ||
                           (i_char >= CH_LA   && i_char <= CH_LF);
        o_class.nibble   = hex_nibble(i_char);
    end

endmodule

/* rtl/can_ascii_frame_parser.sv */
// ============================================================================
// can_ascii_frame_parser - text CAN frame decoder
// Parses ':' S|X <hex id> N <hex data> ';' character streams into frames.
// ============================================================================
// One character beat is taken per clock. A beat lands in an input register,
// and when it is processed the parse state and, on ';', the result register
// are updated, so a frame is presented on the output from the result
// register after its ';' beat leaves the input register. The only stall on
// the input comes from the result register: a ';' that completes a frame
// waits in the input register while the previous frame is still held by a
// stalled consumer, and the characters behind it wait with it. Otherwise
// characters are absorbed regardless of the output side. Malformed frames
// (bad type letter, non-hex digit, too many data bytes, ':' inside a frame)
// are dropped silently and the parser waits for the next ':'.
module can_ascii_frame_parser #(
    parameter int MAX_DATA_BYTES = cafp_pkg::CAFP_MAX_DATA_BYTES
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // character channel
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [cafp_pkg::CHAR_W-1:0] i_ascii_char,
    // frame channel
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic                        o_frame_extended,
    output logic [cafp_pkg::ID_W-1:0]   o_frame_id,
    output logic [cafp_pkg::LEN_W-1:0]  o_frame_len,
    output logic [cafp_pkg::DATA_W-1:0] o_frame_data
);
    import cafp_pkg::*;

    typedef enum logic [1:0] {
        PH_COLON,
        PH_TYPE,
        PH_ID,
        PH_DATA
    } t_phase;

    // input register
    logic              r_in_vld;
    logic [CHAR_W-1:0] r_in_char;

    // parse state
    t_phase            r_phase,  n_phase;
    logic [ID_W-1:0]   r_id,     n_id;
    logic              r_ext,    n_ext;
    logic [LEN_W-1:0]  r_count,  n_count;
    logic              r_high,   n_high;
    logic [BYTE_W-1:0] r_data [MAX_DATA_BYTES];
    logic [BYTE_W-1:0] n_data [MAX_DATA_BYTES];

    // result register
    logic              r_out_vld;
    logic              r_out_ext;
    logic [ID_W-1:0]   r_out_id;
    logic [LEN_W-1:0]  r_out_len;
    logic [DATA_W-1:0] r_out_data, n_out_data;

    t_char_class       w_cls;
    logic              w_emit;
    logic              w_proc;
    logic              w_take;

    cafp_char_decode u_dec (
        .i_char  (r_in_char),
        .o_class (w_cls)
    );

    // ';' in the data phase is the only beat that produces a frame
    assign w_emit  = (r_phase == PH_DATA) && w_cls.is_end;
    assign w_proc  = r_in_vld && (!w_emit || !r_out_vld || !i_stall);
    assign o_stall = r_in_vld && !w_proc;
    assign w_take  = i_valid && !o_stall;

    // next parse state for the held character
    always_comb begin
        n_phase = r_phase;
        n_id    = r_id;
        n_ext   = r_ext;
        n_count = r_count;
        n_high  = r_high;
        for (int k = 0; k < MAX_DATA_BYTES; k++) begin
            n_data[k] = r_data[k];
        end

        unique case (r_phase)
            PH_COLON: begin
                if (w_cls.is_colon) begin
                    n_phase = PH_TYPE;
                    n_id    = '0;
                    n_ext   = 1'b0;
                    n_count = '0;
                    n_high  = 1'b1;
                    for (int k = 0; k < MAX_DATA_BYTES; k++) begin
                        n_data[k] = '0;
                    end
                end
            end
            PH_TYPE: begin
                if (w_cls.is_std) begin
                    n_ext   = 1'b0;
                    n_phase = PH_ID;
                end else if (w_cls.is_ext) begin
                    n_ext   = 1'b1;
                    n_phase = PH_ID;
                end else begin
                    n_phase = PH_COLON;
                end
            end
            PH_ID: begin
                if (w_cls.is_data) begin
                    n_phase = PH_DATA;
                end else if (w_cls.is_hex) begin
                    n_id = {r_id[ID_W-NIB_W-1:0], w_cls.nibble};
                end else begin
                    n_phase = PH_COLON;
                end
            end
            PH_DATA: begin
                if (w_cls.is_end) begin
                    n_phase = PH_COLON;
                end else if (!w_cls.is_hex) begin
                    n_phase = PH_COLON;
                end else if (r_high) begin
                    // start a new byte, unless the frame is already full
                    if (r_count >= LEN_W'(MAX_DATA_BYTES)) begin
                        n_phase = PH_COLON;
                    end else begin
                        for (int k = 0; k < MAX_DATA_BYTES; k++) begin
                            if (r_count == LEN_W'(k)) begin
                                n_data[k] = {{(BYTE_W-NIB_W){1'b0}}, w_cls.nibble};
                            end
                        end
                        n_count = r_count + LEN_W'(1);
                        n_high  = 1'b0;
                    end
                end else begin
                    // second digit: shift into the byte opened last
                    for (int k = 0; k < MAX_DATA_BYTES; k++) begin
                        if (r_count == LEN_W'(k + 1)) begin
                            n_data[k] = {r_data[k][NIB_W-1:0], w_cls.nibble};
                        end
                    end
                    n_high = 1'b1;
                end
            end
            default: n_phase = PH_COLON;
        endcase
    end

    // bytes never opened were cleared at ':'; slots past the limit stay zero
    always_comb begin
        n_out_data = '0;
        for (int k = 0; k < MAX_DATA_BYTES; k++) begin
            n_out_data[BYTE_W*k +: BYTE_W] = r_data[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_phase   <= PH_COLON;
            r_id      <= '0;
            r_ext     <= 1'b0;
            r_count   <= '0;
            r_high    <= 1'b1;
            for (int k = 0; k < MAX_DATA_BYTES; k++) begin
                r_data[k] <= '0;
            end
        end else begin
            if (w_take) begin
                r_in_vld  <= 1'b1;
                r_in_char <= i_ascii_char;
            end else if (w_proc) begin
                r_in_vld  <= 1'b0;
            end

            if (w_proc) begin
                r_phase <= n_phase;
                r_id    <= n_id;
                r_ext   <= n_ext;
                r_count <= n_count;
                r_high  <= n_high;
                for (int k = 0; k < MAX_DATA_BYTES; k++) begin
                    r_data[k] <= n_data[k];
                end
            end

            if (w_proc && w_emit) begin
                r_out_vld  <= 1'b1;
                r_out_ext  <= r_ext;
                r_out_id   <= r_id;
                r_out_len  <= r_count;
                r_out_data <= n_out_data;
            end else if (!i_stall) begin
                r_out_vld  <= 1'b0;
            end
        end
    end

    assign o_valid          = r_out_vld;
    assign o_frame_extended = r_out_ext;
    assign o_frame_id       = r_out_id;
    assign o_frame_len      = r_out_len;
    assign o_frame_data     = r_out_data;

endmodule

/* rtl/cafp_checker.sv */
// ============================================================================
// cafp_checker - port level checks for the CAN ASCII frame parser
// Watches the top level ports; attached by the bind at the end of this file.
// ============================================================================
module cafp_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_valid,
    input logic                        o_stall,
    input logic [cafp_pkg::CHAR_W-1:0] i_ascii_char,
    input logic                        o_valid,
    input logic                        i_stall,
    input logic                        o_frame_extended,
    input logic [cafp_pkg::ID_W-1:0]   o_frame_id,
    input logic [cafp_pkg::LEN_W-1:0]  o_frame_len,
    input logic [cafp_pkg::DATA_W-1:0] o_frame_data
);
    import cafp_pkg::*;

    // nothing comes out right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("frame valid right after reset");

    // input backs up only behind a held, stalled frame
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a blocked frame");

    // byte count never exceeds eight
    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_frame_len <= LEN_W'(8)))
        else $error("frame length out of range");

    // bytes past the count are zero
    a_data_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_frame_len < LEN_W'(8)) |->
            ((o_frame_data >> {o_frame_len, 3'b000}) == '0))
        else $error("data beyond frame length not zero");

    // held frame stays put under stall
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_frame_id) &&
            $stable(o_frame_data) && $stable(o_frame_len) &&
            $stable(o_frame_extended)))
        else $error("stalled frame changed");

endmodule

bind can_ascii_frame_parser cafp_checker u_cafp_checker (.*);

/* test/can_ascii_frame_parser_tb.sv */
// ============================================================================
// can_ascii_frame_parser_tb - self-checking bench for the CAN ASCII parser
// Drives character beats, predicts each decoded frame and checks every field.
// ============================================================================
// Character beats are driven on the falling edge. Each accepted character
// goes through a predictor that tracks its own parse state and queues a
// frame when ';' closes the data phase. A checker pops that queue for every
// accepted frame beat and compares the fields one by one.
//
// The sender works in bursts with random gaps between them. The receiver
// holds stall in runs of random length. Each test sets how hard both sides
// press. A watchdog ends the run if no beat moves on either side for too long.
module can_ascii_frame_parser_tb;
    import cafp_pkg::*;

    localparam int MAX_BYTES      = CAFP_MAX_DATA_BYTES;
    localparam int RANDOM_CHARS   = 480;
    localparam int SETTLE_CYCLES  = 8;    // result path: input register, then result register
    localparam int WATCHDOG_LIMIT = 2000;

    // frame as seen on the output channel
    typedef struct packed {
        logic              ext;
        logic [ID_W-1:0]   id;
        logic [LEN_W-1:0]  len;
        logic [DATA_W-1:0] data;
    } t_frame;

    typedef enum logic [1:0] {
        AWAIT_COLON,
        AWAIT_TYPE,
        IN_ID,
        IN_DATA
    } t_parse_phase;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_stall;
    logic [CHAR_W-1:0] i_ascii_char;
    logic              o_valid;
    logic              i_stall;
    logic              o_frame_extended;
    logic [ID_W-1:0]   o_frame_id;
    logic [LEN_W-1:0]  o_frame_len;
    logic [DATA_W-1:0] o_frame_data;

    // predictor state
    t_parse_phase      rx_phase;
    logic [ID_W-1:0]   rx_id;
    logic              rx_ext;
    logic [LEN_W-1:0]  rx_nbytes;
    logic [BYTE_W-1:0] rx_bytes [MAX_BYTES];
    logic              rx_hi_nibble;

    t_frame      pending_frames[$];
    int unsigned mismatch_count = 0;
    int unsigned chars_parsed   = 0;   // characters the parser does not ignore

    // pressure knobs, set by each test
    int stall_pct     = 0;
    int stall_run_max = 1;
    int gap_max       = 0;
    int burst_max     = 1;
    int burst_left    = 0;
    int stall_run     = 0;
    bit stall_hold    = 1'b0;

    can_ascii_frame_parser #(
        .MAX_DATA_BYTES (MAX_BYTES)
    ) u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_ascii_char     (i_ascii_char),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_frame_extended (o_frame_extended),
        .o_frame_id       (o_frame_id),
        .o_frame_len      (o_frame_len),
        .o_frame_data     (o_frame_data)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Receiver stall: runs of random length, stalled with probability stall_pct.
    always @(negedge i_clk) begin
        if (stall_run == 0) begin
            stall_hold = ($urandom_range(0, 99) < stall_pct);
            stall_run  = $urandom_range(1, stall_run_max);
        end
        stall_run = stall_run - 1;
        i_stall <= stall_hold;
    end

    task automatic report_mismatch(input string what);
        $display("MISMATCH @%0t: %s", $time, what);
        mismatch_count++;
    endtask

    // -1 for anything that is not a hex digit
    function automatic int digit_value(input logic [CHAR_W-1:0] c);
        if (c >= CH_DIG0 && c <= CH_DIG9) return int'(c - CH_DIG0);
        if (c >= CH_UA && c <= CH_UF) return int'(c - CH_UA) + 10;
        if (c >= CH_LA && c <= CH_LF) return int'(c - CH_LA) + 10;
        return -1;
    endfunction

    function automatic logic [CHAR_W-1:0] hex_char(input logic [NIB_W-1:0] n, input bit lower);
        if (n < NIB_W'(10)) return CH_DIG0 + CHAR_W'(n);
        return (lower ? CH_LA : CH_UA) + CHAR_W'(n - NIB_W'(10));
    endfunction

    // Advance the predicted parse by one accepted character; queue a frame on ';'.
    task automatic predict_char(input logic [CHAR_W-1:0] c);
        int     nib;
        t_frame f;
        nib = digit_value(c);
        if (rx_phase != AWAIT_COLON || c == CH_COLON) chars_parsed++;
        case (rx_phase)
            AWAIT_COLON: begin
                if (c == CH_COLON) begin
                    rx_id        = '0;
                    rx_ext       = 1'b0;
                    rx_nbytes    = '0;
                    rx_hi_nibble = 1'b1;
                    foreach (rx_bytes[k]) rx_bytes[k] = '0;
                    rx_phase     = AWAIT_TYPE;
                end
            end
            AWAIT_TYPE: begin
                if (c == CH_STD) begin
                    rx_ext   = 1'b0;
                    rx_phase = IN_ID;
                end else if (c == CH_EXT) begin
                    rx_ext   = 1'b1;
                    rx_phase = IN_ID;
                end else begin
                    rx_phase = AWAIT_COLON;
                end
            end
            IN_ID: begin
                if (c == CH_DATA) begin
                    rx_phase = IN_DATA;
                end else if (nib < 0) begin
                    rx_phase = AWAIT_COLON;
                end else begin
                    // shift a nibble in, upper bits fall off
                    rx_id = {rx_id[ID_W-NIB_W-1:0], nib[NIB_W-1:0]};
                end
            end
            IN_DATA: begin
                if (c == CH_END) begin
                    f.ext  = rx_ext;
                    f.id   = rx_id;
                    f.len  = rx_nbytes;
                    f.data = '0;
                    for (int k = 0; k < MAX_BYTES; k++) begin
                        if (k < rx_nbytes) f.data[BYTE_W*k +: BYTE_W] = rx_bytes[k];
                    end
                    pending_frames.push_back(f);
                    rx_phase = AWAIT_COLON;
                end else if (nib < 0) begin
                    rx_phase = AWAIT_COLON;
                end else if (rx_hi_nibble) begin
                    // a new byte would not fit: frame is dropped
                    if (rx_nbytes >= MAX_BYTES) begin
                        rx_phase = AWAIT_COLON;
                    end else begin
                        rx_bytes[rx_nbytes] = BYTE_W'(nib);
                        rx_nbytes           = rx_nbytes + LEN_W'(1);
                        rx_hi_nibble        = 1'b0;
                    end
                end else begin
                    rx_bytes[rx_nbytes-1] = {rx_bytes[rx_nbytes-1][NIB_W-1:0], nib[NIB_W-1:0]};
                    rx_hi_nibble          = 1'b1;
                end
            end
        endcase
    endtask

    // One character beat. A burst boundary may put an idle gap in front of it;
    // during the gap the data lines carry junk to show they are ignored.
    task automatic send_char(input logic [CHAR_W-1:0] c);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, gap_max);
            repeat (gap) begin
                @(negedge i_clk);
                i_valid      <= 1'b0;
                i_ascii_char <= CHAR_W'($urandom_range(0, 255));
            end
            burst_left = $urandom_range(1, burst_max);
        end
        burst_left--;
        @(negedge i_clk);
        i_valid      <= 1'b1;
        i_ascii_char <= c;
        do @(posedge i_clk); while (o_stall);
        predict_char(c);
    endtask

    task automatic send_text(input string s);
        for (int k = 0; k < s.len(); k++) send_char(s[k]);
    endtask

    // Sender holds off until every queued frame has come out.
    task automatic wait_frames_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_frames.size() != 0) @(posedge i_clk);
        burst_left = 0;
    endtask

    // Mostly well-formed frames with random content; some are broken on purpose.
    task automatic send_random_frame(input int id_max, input int data_max);
        logic [CHAR_W-1:0] text[$];
        int                n_id;
        int                n_data;
        int                pos;
        n_id   = $urandom_range(0, id_max);
        n_data = $urandom_range(0, data_max);
        // a little noise between frames
        repeat ($urandom_range(0, 2)) text.push_back(CHAR_W'($urandom_range(0, 255)));
        text.push_back(CH_COLON);
        if ($urandom_range(0, 19) == 0) text.push_back(CHAR_W'($urandom_range(0, 255)));
        else text.push_back($urandom_range(0, 1) ? CH_EXT : CH_STD);
        repeat (n_id)
            text.push_back(hex_char(NIB_W'($urandom_range(0, 15)),
                                    1'($urandom_range(0, 1))));
        text.push_back(CH_DATA);
        repeat (n_data)
            text.push_back(hex_char(NIB_W'($urandom_range(0, 15)),
                                    1'($urandom_range(0, 1))));
        // occasionally drop the terminator so the next frame's ':' lands mid-frame
        if ($urandom_range(0, 19) != 0) text.push_back(CH_END);
        // one character replaced by random junk
        if ($urandom_range(0, 9) == 0) begin
            pos       = $urandom_range(0, text.size() - 1);
            text[pos] = CHAR_W'($urandom_range(0, 255));
        end
        foreach (text[k]) send_char(text[k]);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Anything before ':' is ignored, including frame letters and extreme codes.
    task automatic test_noise_before_colon();
        gap_max   = 2;
        burst_max = 4;
        stall_pct = 0;
        send_char(8'h00);
        send_char(8'hFF);
        send_char(8'h80);
        send_text("SN;7F;");
        send_text(":S0N;");
    endtask

    // Both frame types, identifier extremes, hex case mix, identifier wrap.
    task automatic test_frame_types_and_ids();
        gap_max       = 3;
        burst_max     = 6;
        stall_pct     = 30;
        stall_run_max = 3;
        send_text(":S7FFN0102030405060708;");
        send_text(":XFFFFFFFFNFFFFFFFFFFFFFFFF;");
        send_text(":X1fffffffN;");
        send_text(":SabcdefNa1B2c3D4;");
        send_text(":X123456789ABCN00;");   // only the last 8 digits survive
        send_text(":SN;");                 // empty identifier
    endtask

    // Data lengths from one nibble to full, odd digit counts, and a ninth byte.
    task automatic test_data_lengths();
        gap_max       = 1;
        burst_max     = 3;
        stall_pct     = 50;
        stall_run_max = 5;
        send_text(":S1N5;");                           // single lone nibble
        send_text(":S2N123;");                         // odd count, last byte half full
        send_text(":S3N0123456789abcde;");             // fifteen digits
        send_text(":S4N0123456789ABCDEF;");            // all eight bytes
        send_text(":S5N0123456789ABCDEF0;");           // a ninth byte drops the frame
        send_text(":S6N0123456789ABCDEF01;");
    endtask

    // Malformed frames that must vanish without a result.
    task automatic test_malformed_frames();
        gap_max       = 2;
        burst_max     = 5;
        stall_pct     = 20;
        stall_run_max = 2;
        send_text(":s1N;");       // lower-case type letter
        send_text(":N1;");        // missing type
        send_text("::S1N;");      // colon where the type goes
        send_text(":S12G3N;");    // bad digit in identifier
        send_text(":S1;");        // terminator inside identifier
        send_text(":S12N1g;");    // bad digit in data
        send_text(":S1N1N;");     // second N
        send_text(":S1:X5N;");    // colon inside identifier, rest ignored
        send_text(":S1N12:S2N;"); // colon inside data, rest ignored
        send_char(CH_COLON);
        send_char(CH_STD);
        send_char(8'hFF);         // top-bit character in identifier
        send_text(":XN1");
        send_char(8'h80);         // top-bit character in data
        send_text(":X0N;");       // good frame to show recovery
    endtask

    // Random traffic in four pressure settings, with a full drain in the middle.
    task automatic test_random_traffic();
        int goal;
        for (int seg = 0; seg < 4; seg++) begin
            case (seg)
                0: begin          // full rate, no stalls
                    gap_max   = 0;
                    burst_max = 64;
                    stall_pct = 0;
                end
                1: begin          // bursty sender, light stalls
                    gap_max       = 6;
                    burst_max     = 12;
                    stall_pct     = 25;
                    stall_run_max = 3;
                end
                2: begin          // heavy stalls with short frames so ';' backs up
                    gap_max       = 0;
                    burst_max     = 64;
                    stall_pct     = 75;
                    stall_run_max = 10;
                end
                default: begin
                    gap_max       = 3;
                    burst_max     = 8;
                    stall_pct     = 40;
                    stall_run_max = 6;
                end
            endcase
            if (seg == 2) wait_frames_drained();
            goal = chars_parsed + RANDOM_CHARS / 4;
            while (chars_parsed < goal) begin
                if (seg == 2) send_random_frame(3, 4);
                else send_random_frame(10, 18);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Result checker: every accepted frame beat against the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : frame_check
        t_frame want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_frames.size() == 0) begin
                report_mismatch($sformatf("unexpected frame id %h len %0d",
                                          o_frame_id, o_frame_len));
            end else begin
                want = pending_frames.pop_front();
                if (o_frame_extended !== want.ext)
                    report_mismatch($sformatf("extended %b, want %b",
                                              o_frame_extended, want.ext));
                if (o_frame_id !== want.id)
                    report_mismatch($sformatf("id %h, want %h", o_frame_id, want.id));
                if (o_frame_len !== want.len)
                    report_mismatch($sformatf("len %0d, want %0d", o_frame_len, want.len));
                if (o_frame_data !== want.data)
                    report_mismatch($sformatf("data %h, want %h", o_frame_data, want.data));
            end
        end
    end

    // Watchdog: quiet cycles on both channels
    initial begin : watchdog
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        wait (i_rst_n === 1'b1);
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) quiet_cycles = 0;
            else quiet_cycles++;
        end
        $display("FAILURE");
        $finish;
    end

    initial begin
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_ascii_char = '0;
        i_stall      = 1'b0;
        rx_phase     = AWAIT_COLON;
        rx_id        = '0;
        rx_ext       = 1'b0;
        rx_nbytes    = '0;
        rx_hi_nibble = 1'b1;
        foreach (rx_bytes[k]) rx_bytes[k] = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_noise_before_colon();
        test_frame_types_and_ids();
        test_data_lengths();
        test_malformed_frames();
        test_random_traffic();

        wait_frames_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pending_frames.size() != 0)
            report_mismatch($sformatf("%0d frames never came out", pending_frames.size()));

        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

/* can_ascii_frame_parser.f */
rtl/cafp_pkg.sv
rtl/cafp_char_decode.sv
rtl/can_ascii_frame_parser.sv
rtl/cafp_checker.sv
test/can_ascii_frame_parser_tb.sv
